// ===== hw/rtl/gcd_lcm_unit_defines.svh =====
// Assertion macros used by the file that checks this block.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GCDLCM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GCDLCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gcdlcm_pkg.sv =====
`default_nettype none

package gcdlcm_pkg;

  // Field widths of the request and result.
  localparam int FieldW = 31;
  localparam int GcdW   = 31;
  localparam int LcmW   = 62;

  // Number of operand bits used by the arithmetic.
  localparam int OpW    = 31;
  localparam int ProdW  = 2 * OpW;
  // Counter width for the shift count and the divider steps (both at most OpW).
  localparam int CntW   = $clog2(OpW);

  typedef struct packed {
    logic [FieldW-1:0] first_value;
    logic [FieldW-1:0] second_value;
  } req_t;

  typedef struct packed {
    logic [GcdW-1:0] gcd_value;
    logic [LcmW-1:0] lcm_value;
  } res_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_HALVE_BOTH,
    CMD_HALVE_X,
    CMD_HALVE_Y,
    CMD_SUB,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_MUL
  } dp_cmd_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic any_zero;
    logic both_even;
    logic x_even;
    logic y_even;
    logic y_zero;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gcd_lcm_unit.sv =====
`default_nettype none

// GCD and LCM unit. A request is taken at a rising edge where start is high and busy is
// low; busy then rises the next cycle. If either operand is zero the request ends in the
// check state with no result. Otherwise the unit runs a binary GCD and then the LCM as
// (first / gcd) * second at full 62-bit width. In order, the unit halves both operands
// by the trailing zeros they share, halves the first operand by its remaining trailing
// zeros, runs the halve-or-subtract loop of the GCD, shifts the odd GCD back by the shared
// zeros, divides the first operand by the GCD in the 31-step bit-serial restoring divider,
// multiplies the quotient by the second operand in the 31x31 multiplier and shows the
// result. The result stands on res_o for exactly one cycle with done_o high and must be
// taken then: the receiver cannot stall the unit. busy falls in the same cycle, so a new
// request may be given while the result is shown.

`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit
  import gcdlcm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output res_t      res_o
);

  dp_cmd_e    cmd;
  dp_status_t status;

  // Sequencer.
  gcdlcm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Arithmetic.
  gcdlcm_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .res_o    (res_o)
  );

  // A taken request always makes the unit busy.
  `GCDLCM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "request not taken")
  // A result is only shown when the unit has finished.
  `GCDLCM_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy, "result while busy")
  // A result strobe lasts a single cycle.
  `GCDLCM_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result repeated")
  // Both results of a nonzero pair are nonzero.
  `GCDLCM_ASSERT_SAME(a_res_nonzero, clk_i, rst_ni, done_o,
                      (res_o.gcd_value != '0) && (res_o.lcm_value != '0), "zero result")

endmodule

`default_nettype wire

// ===== hw/rtl/gcdlcm_dpath.sv =====
`default_nettype none

module gcdlcm_dpath
  import gcdlcm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire req_t       req_i,
  input  wire dp_cmd_e    cmd_i,
  output dp_status_t      status_o,
  output res_t            res_o
);

  logic [OpW-1:0]   x_q, x_d;
  logic [OpW-1:0]   y_q, y_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [OpW-1:0]   a_q, a_d;
  logic [OpW-1:0]   b_q, b_d;
  logic [OpW-1:0]   g_q, g_d;
  logic [OpW-1:0]   rem_q, rem_d;
  logic [OpW-1:0]   quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ProdW-1:0] lcm_q, lcm_d;

  logic [OpW:0]     rem_shift;
  logic             rem_fits;
  logic             x_gt_y;

  // One restoring division step: bring down the next dividend bit and try the divisor.
  assign rem_shift = {rem_q, quo_q[OpW-1]};
  assign rem_fits  = rem_shift >= {1'b0, g_q};
  assign x_gt_y    = x_q > y_q;

  // Next values of the working registers, one command per cycle.
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    k_d   = k_q;
    a_d   = a_q;
    b_d   = b_q;
    g_d   = g_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    lcm_d = lcm_q;
    case (cmd_i)
      CMD_LOAD: begin
        x_d = OpW'(req_i.first_value);
        y_d = OpW'(req_i.second_value);
        a_d = OpW'(req_i.first_value);
        b_d = OpW'(req_i.second_value);
        k_d = '0;
      end
      CMD_HALVE_BOTH: begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + CntW'(1);
      end
      CMD_HALVE_X: begin
        x_d = x_q >> 1;
      end
      CMD_HALVE_Y: begin
        y_d = y_q >> 1;
      end
      CMD_SUB: begin
        // Keep the smaller value in x and the difference in y.
        if (x_gt_y) begin
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      CMD_DIV_INIT: begin
        g_d   = x_q << k_q;
        rem_d = '0;
        quo_d = a_q;
        cnt_d = '0;
      end
      CMD_DIV_STEP: begin
        // The partial remainder always stays below the divisor.
        if (rem_fits) begin
          rem_d = OpW'(rem_shift - {1'b0, g_q});
        end else begin
          rem_d = rem_shift[OpW-1:0];
        end
        quo_d = {quo_q[OpW-2:0], rem_fits};
        cnt_d = cnt_q + CntW'(1);
      end
      CMD_MUL: begin
        lcm_d = ProdW'(quo_q) * ProdW'(b_q);
      end
      default: begin
      end
    endcase
  end

  // The step counter is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    k_q   <= k_d;
    a_q   <= a_d;
    b_q   <= b_d;
    g_q   <= g_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    lcm_q <= lcm_d;
  end

  // Status for the controller.
  always_comb begin
    status_o.any_zero  = (x_q == '0) || (y_q == '0);
    status_o.both_even = !x_q[0] && !y_q[0];
    status_o.x_even    = !x_q[0];
    status_o.y_even    = !y_q[0];
    status_o.y_zero    = y_q == '0;
    status_o.div_last  = cnt_q == CntW'(OpW - 1);
  end

  assign res_o.gcd_value = GcdW'(g_q);
  assign res_o.lcm_value = LcmW'(lcm_q);

endmodule

`default_nettype wire

// ===== hw/rtl/gcdlcm_ctrl.sv =====
`default_nettype none

module gcdlcm_ctrl
  import gcdlcm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output dp_cmd_e         cmd_o,
  output logic            busy_o,
  output logic            done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ODD_X,
    ST_LOOP,
    ST_DIV,
    ST_MUL
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // Command for the datapath in the current state.
  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o = CMD_LOAD;
        end
      end
      ST_CHECK: begin
        if (!status_i.any_zero && status_i.both_even) begin
          cmd_o = CMD_HALVE_BOTH;
        end
      end
      ST_ODD_X: begin
        if (status_i.x_even) begin
          cmd_o = CMD_HALVE_X;
        end
      end
      ST_LOOP: begin
        if (status_i.y_zero) begin
          cmd_o = CMD_DIV_INIT;
        end else if (status_i.y_even) begin
          cmd_o = CMD_HALVE_Y;
        end else begin
          cmd_o = CMD_SUB;
        end
      end
      ST_DIV: begin
        cmd_o = CMD_DIV_STEP;
      end
      ST_MUL: begin
        cmd_o = CMD_MUL;
      end
      default: begin
        cmd_o = CMD_NONE;
      end
    endcase
  end

  // State sequence, busy flag and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_CHECK;
            busy_q  <= 1'b1;
          end
        end
        ST_CHECK: begin
          // A zero operand ends the request without a result.
          if (status_i.any_zero) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end else if (!status_i.both_even) begin
            state_q <= ST_ODD_X;
          end
        end
        ST_ODD_X: begin
          if (!status_i.x_even) begin
            state_q <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (status_i.y_zero) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (status_i.div_last) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== tb/sv/gcd_lcm_unit_test.sv =====
`timescale 1ns / 1ps

module gcd_lcm_unit_test;
  import gcdlcm_pkg::*;

  localparam int CycleLimit     = 1_000_000;
  localparam int RandomRequests = 650;
  localparam int CalmTail       = 80;
  localparam int DrainCycles    = 200;
  localparam int NumRows        = 20;

  localparam logic [FieldW-1:0] MaxOperand = {FieldW{1'b1}};
  localparam logic [FieldW-1:0] TopBit     = {1'b1, {(FieldW-1){1'b0}}};

  // One row of the directed table. When typed is set the expected result is given
  // in the row; otherwise it comes from the GCD/LCM predictor.
  typedef struct packed {
    logic [FieldW-1:0] first_op;
    logic [FieldW-1:0] second_op;
    logic              typed;
    logic              gives;
    logic [GcdW-1:0]   gcd;
    logic [LcmW-1:0]   lcm;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  res_t pending_results[$];
  int   cycle_count;
  int   mismatches;
  int   n_requests;
  int   n_zero_requests;
  int   n_results;
  int   quiet_left;

  stim_row_t stim_table [NumRows] = '{
    '{31'd0,       31'd0,           1'b1, 1'b0, 31'd0,      62'd0},
    '{31'd0,       31'd12345,       1'b1, 1'b0, 31'd0,      62'd0},
    '{MaxOperand,  31'd0,           1'b1, 1'b0, 31'd0,      62'd0},
    '{31'd0,       MaxOperand,      1'b1, 1'b0, 31'd0,      62'd0},
    '{31'd1,       31'd0,           1'b1, 1'b0, 31'd0,      62'd0},
    '{31'd1,       31'd1,           1'b1, 1'b1, 31'd1,      62'd1},
    '{MaxOperand,  MaxOperand,      1'b1, 1'b1, MaxOperand, 62'd2147483647},
    '{MaxOperand,  31'd1,           1'b1, 1'b1, 31'd1,      62'd2147483647},
    '{31'd1,       MaxOperand,      1'b1, 1'b1, 31'd1,      62'd2147483647},
    '{MaxOperand,  MaxOperand - 1,  1'b1, 1'b1, 31'd1,      62'd4611686011984936962},
    '{TopBit,      TopBit,          1'b1, 1'b1, TopBit,     62'd1073741824},
    '{TopBit,      31'd1,           1'b1, 1'b1, 31'd1,      62'd1073741824},
    '{31'd1,       TopBit,          1'b1, 1'b1, 31'd1,      62'd1073741824},
    '{31'd12,      31'd18,          1'b1, 1'b1, 31'd6,      62'd36},
    '{TopBit,      31'd1610612736,  1'b0, 1'b0, 31'd0,      62'd0},
    '{31'h55555555, 31'h2AAAAAAA,   1'b0, 1'b0, 31'd0,      62'd0},
    '{31'h2AAAAAAA, 31'h55555555,   1'b0, 1'b0, 31'd0,      62'd0},
    '{31'd1836311903, 31'd1134903170, 1'b0, 1'b0, 31'd0,    62'd0},
    '{31'd1073741825, 31'd1073741823, 1'b0, 1'b0, 31'd0,    62'd0},
    '{31'd201326592, TopBit,        1'b0, 1'b0, 31'd0,      62'd0}
  };

  gcd_lcm_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #1 clk_i = ~clk_i;

  // Expected GCD and LCM of one request; returns 0 when a zero operand gives no result.
  function automatic bit predict_gcd_lcm(input req_t r, output res_t res);
    logic [63:0] op_mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] rem;
    logic [63:0] lcm;
    op_mask = (64'd1 << OpW) - 64'd1;
    a = 64'(r.first_value) & op_mask;
    b = 64'(r.second_value) & op_mask;
    res = '0;
    if (a == 64'd0 || b == 64'd0) return 1'b0;
    x = a;
    y = b;
    while (y != 64'd0) begin
      rem = x % y;
      x = y;
      y = rem;
    end
    lcm = (a / x) * b;
    res.gcd_value = x[GcdW-1:0];
    res.lcm_value = lcm[LcmW-1:0];
    return 1'b1;
  endfunction

  // One operand drawn from a mix of shapes: zero, full range, small, power-of-two
  // multiples, top bit set, and scaled-down magnitudes.
  function automatic logic [FieldW-1:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return '0;
    if (pick < 30) return FieldW'($urandom());
    if (pick < 50) return FieldW'($urandom_range(1, 1000));
    if (pick < 65) return FieldW'($urandom_range(1, 255) << $urandom_range(0, 22));
    if (pick < 80) return {1'b1, (FieldW-1)'($urandom())};
    return FieldW'($urandom()) >> $urandom_range(0, FieldW - 1);
  endfunction

  // Pairs that share a factor, equal pairs and multiples; otherwise independent operands.
  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    int unsigned common;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      common = $urandom_range(1, 32767);
      r.first_value  = FieldW'(common * $urandom_range(1, 32767));
      r.second_value = FieldW'(common * $urandom_range(1, 32767));
    end else if (pick < 36) begin
      r.first_value  = random_operand();
      r.second_value = r.first_value;
    end else if (pick < 42) begin
      r.second_value = FieldW'($urandom_range(1, 65535));
      r.first_value  = FieldW'(r.second_value * $urandom_range(1, 32767));
    end else begin
      r.first_value  = random_operand();
      r.second_value = random_operand();
    end
    return r;
  endfunction

  // Hold the request with start high until the unit takes it, record the expected
  // result, then perhaps leave a random gap before the next request.
  task automatic send_request(input req_t r, input bit typed, input bit typed_gives,
                              input res_t typed_res, input bit allow_idle);
    res_t want;
    bit   gives;
    int   gap;
    start = 1'b1;
    req_i = r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    gives = predict_gcd_lcm(r, want);
    if (typed) begin
      gives = typed_gives;
      want  = typed_res;
    end
    if (gives) pending_results.push_back(want);
    else n_zero_requests++;
    n_requests++;
    @(negedge clk_i);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if (allow_idle && $urandom_range(0, 9) < 4) begin
      gap = $urandom_range(1, 14);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end else if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(5, 30);
    end
  endtask

  // Timeout, and comparison of each result strobe with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: gcd_value %0d lcm_value %0d",
               res_o.gcd_value, res_o.lcm_value);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (res_o.gcd_value !== want.gcd_value) begin
          $error("gcd_value: expected %0d, actual %0d", want.gcd_value, res_o.gcd_value);
          mismatches++;
        end
        if (res_o.lcm_value !== want.lcm_value) begin
          $error("lcm_value: expected %0d, actual %0d", want.lcm_value, res_o.lcm_value);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    req_t r;
    res_t typed_res;
    // Hold reset, then release it on a falling edge.
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: zero operands, extremes, shared powers of two, alternating bits.
    for (int i = 0; i < NumRows; i++) begin
      r.first_value       = stim_table[i].first_op;
      r.second_value      = stim_table[i].second_op;
      typed_res.gcd_value = stim_table[i].gcd;
      typed_res.lcm_value = stim_table[i].lcm;
      send_request(r, stim_table[i].typed, stim_table[i].gives, typed_res, 1'b1);
    end

    // Random requests; the last stretch runs back to back.
    typed_res = '0;
    for (int i = 0; i < RandomRequests; i++) begin
      send_request(random_request(), 1'b0, 1'b0, typed_res,
                   i < RandomRequests - CalmTail);
    end
    start = 1'b0;

    // Drain outstanding results, then let the last request finish.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests (%0d with a zero operand) and checked %0d results.",
             n_requests, n_zero_requests, n_results);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
